[sv/dtgr_pkg.sv]
// dtgr_pkg: shared constants, codes and the quarter-wave sine rom contents
// for the ramped dual-tone generator; no dependencies
`timescale 1ns / 1ps

package dtgr_pkg;

	localparam int PHASE_BITS  = 32;
	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_ABITS  = $clog2(SINE_DEPTH);
	localparam int ROM_ABITS   = SINE_ABITS + 1;
	localparam int SINE_WBITS  = 15;
	localparam int RAMP_MAX    = 1024;
	localparam int RAMP_BITS   = 11;
	localparam int CNT_BITS    = 24;
	localparam int AMP_BITS    = 15;
	localparam int CFG_ABITS   = 3;
	localparam int CFG_DBITS   = 32;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TAYLOR_DIV [1:6] = '{6, 20, 42, 72, 110, 156};

	// configuration register indexes
	typedef enum logic [CFG_ABITS-1:0] {
		CFG_PHASE_STEP_0   = 3'd0,
		CFG_PHASE_STEP_1   = 3'd1,
		CFG_AMPLITUDE_0    = 3'd2,
		CFG_AMPLITUDE_1    = 3'd3,
		CFG_RAMP_SAMPLES   = 3'd4,
		CFG_RAMP_STEP      = 3'd5,
		CFG_CENTER_SAMPLES = 3'd6
	} cfg_index_t;

	typedef enum logic [1:0] {
		REG_RISE   = 2'd0,
		REG_CENTER = 2'd1,
		REG_FALL   = 2'd2
	} region_t;

	typedef logic [SINE_WBITS-1:0] sine_rom_t [0:SINE_DEPTH];

	// sin(pi/2 * i / depth) in q15, taylor series in q30
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t       rom;
		longint unsigned x;
		longint unsigned term;
		longint          sum;
		longint          v;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			x    = (HALF_PI_Q30 * longint'(i)) / SINE_DEPTH;
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / TAYLOR_DIV[k];
				if ((k % 2) == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
			if (v > 32767)
				v = 32767;
			rom[i] = v[SINE_WBITS-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[sv/dual_tone_generator_ramped_unit.sv]
// dual_tone_generator_ramped_unit: top level of the ramped dual-tone generator
// depends on dtgr_pkg (constants, codes, sine rom contents)
`timescale 1ns / 1ps

// usage
//  - configuration: cfg_we / cfg_addr / cfg_wdata write one register per cycle;
//    the user writes only while no tick is in flight; the block does not enforce it
//  - input stream (s_*): s_tuser[0] is the action (0 start tone, 1 sample tick),
//    s_tdata[0] is halt; a start clears all oscillator and envelope phases
//  - output stream (m_*): one transaction per produced sample, m_tdata the
//    signed sample, m_tuser the region, m_tlast marks the final sample of a tone
//  - a tick passes S_A, S_B, S_E, S_ESQ, S_SCALE and S_OUT to reach the output
//    register, and waits in S_OUT while that register is full and the receiver
//    stalls; no new item is taken until the tick is back in S_IDLE; its three
//    phases are read from and written back to one small phase ram, one after
//    another, and the sine rom plus the shared multiplier sit behind those reads
//  - a start is accepted, then S_CLR clears the three phase ram entries in turn
//  - idle ticks and ticks that end a tone with no sample finish in S_IDLE
//  - s_tready is high only between items; a stalled receiver holds the last
//    sample in the output register and the next tick waits at its last stage
//  - after reset all configuration and control registers are zero and no tone is active
module dual_tone_generator_ramped_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [dtgr_pkg::CFG_ABITS-1:0] cfg_addr,
	input  logic [dtgr_pkg::CFG_DBITS-1:0] cfg_wdata,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [0] halt, [7:1] zero
	input  logic [0:0]                     s_tuser,   // [0] action
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,   // [15:0] sample
	output logic [1:0]                     m_tuser,   // [1:0] region
	output logic                           m_tlast
);

	localparam int PB = dtgr_pkg::PHASE_BITS;
	localparam int CB = dtgr_pkg::CNT_BITS;
	localparam int WB = dtgr_pkg::SINE_WBITS;

	// phase ram entries
	localparam logic [1:0] PH_A   = 2'd0;
	localparam logic [1:0] PH_B   = 2'd1;
	localparam logic [1:0] PH_ENV = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_A,
		S_B,
		S_E,
		S_ESQ,
		S_SCALE,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [PB-1:0]                    step0_q, step1_q, estep_q;
	logic [dtgr_pkg::AMP_BITS-1:0]    amp0_q, amp1_q;
	logic [dtgr_pkg::RAMP_BITS-1:0]   ramp_q;
	logic [CB-1:0]                    center_q;

	// control state
	logic                             active_q;
	dtgr_pkg::region_t                region_q;
	logic [CB-1:0]                    counter_q;
	logic [1:0]                       clr_q;
	logic                             m_tvalid_q;

	// phase ram
	logic [PB-1:0]                    phase_mem [0:3];
	logic                             pm_we;
	logic [1:0]                       pm_waddr, pm_raddr;
	logic [PB-1:0]                    pm_wdata, pm_rdata_q;

	// sine rom
	logic [dtgr_pkg::ROM_ABITS-1:0]   rom_addr;
	logic [WB-1:0]                    rom_q;
	logic                             sneg_q;

	// datapath
	logic [PB-1:0]                    lk_phase, env_dec, env_inc;
	logic [1:0]                       quad;
	logic [dtgr_pkg::SINE_ABITS-1:0]  tab_j;
	logic signed [15:0]               s_val;
	logic [dtgr_pkg::AMP_BITS-1:0]    amp_sel;
	logic signed [31:0]               mul_amp;
	logic signed [31:0]               prod0_s1, mix_q;
	logic [31:0]                      mix_neg;
	logic [29:0]                      esq_q;
	logic [30:0]                      mag_q;
	logic                             neg_q;
	logic [60:0]                      scaled;
	logic [14:0]                      q_q;
	logic                             last_s;
	logic [15:0]                      sample_out;
	logic                             out_load;

	// region decision
	logic                             in_accept, halt, action;
	logic [dtgr_pkg::RAMP_BITS-1:0]   ramp_eff;
	logic [CB-1:0]                    r_ext, cnt_n, cnt_inc;
	dtgr_pkg::region_t                reg_n;
	logic                             tone_end, last_n;

	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign action    = s_tuser[0];
	assign halt      = s_tdata[0];

	// rise and fall length saturates at the table limit
	assign ramp_eff = (ramp_q > dtgr_pkg::RAMP_BITS'(dtgr_pkg::RAMP_MAX))
		? dtgr_pkg::RAMP_BITS'(dtgr_pkg::RAMP_MAX) : ramp_q;
	assign r_ext    = CB'(ramp_eff);
	assign cnt_inc  = counter_q + CB'(1);

	// skip empty regions within the same tick
	always_comb begin
		reg_n    = region_q;
		cnt_n    = counter_q;
		tone_end = 1'b0;
		if (reg_n == dtgr_pkg::REG_RISE && cnt_n >= r_ext) begin
			reg_n = dtgr_pkg::REG_CENTER;
			cnt_n = '0;
		end
		if (reg_n == dtgr_pkg::REG_CENTER && (cnt_n >= center_q || halt)) begin
			reg_n = dtgr_pkg::REG_FALL;
			cnt_n = '0;
		end
		if (reg_n == dtgr_pkg::REG_FALL && cnt_n >= r_ext)
			tone_end = 1'b1;
	end

	// final sample of the tone, judged on the advanced count
	always_comb begin
		case (region_q)
			dtgr_pkg::REG_FALL:   last_n = (cnt_inc >= r_ext);
			dtgr_pkg::REG_CENTER: last_n = (ramp_eff == '0) && (cnt_inc >= center_q);
			default:              last_n = 1'b0;
		endcase
	end

	// envelope: the rise reads then advances, the fall steps back then reads
	assign env_dec = pm_rdata_q - estep_q;
	assign env_inc = pm_rdata_q + estep_q;

	always_comb begin
		case (state_q)
			S_E:     lk_phase = (region_q == dtgr_pkg::REG_FALL) ? env_dec : pm_rdata_q;
			default: lk_phase = pm_rdata_q;
		endcase
	end

	// quarter-wave lookup: mirror in odd quadrants, negate in the lower half
	assign quad     = lk_phase[PB-1 -: 2];
	assign tab_j    = lk_phase[PB-3 -: dtgr_pkg::SINE_ABITS];
	assign rom_addr = quad[0]
		? dtgr_pkg::ROM_ABITS'(dtgr_pkg::SINE_DEPTH) - {1'b0, tab_j}
		: {1'b0, tab_j};

	always_ff @(posedge clk) begin
		rom_q  <= dtgr_pkg::SINE_ROM[rom_addr];
		sneg_q <= quad[1];
	end

	// phase ram: read-modify-write, one entry per cycle
	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = PH_A;
		pm_wdata = pm_rdata_q;
		case (state_q)
			S_CLR: begin
				pm_we    = 1'b1;
				pm_waddr = clr_q;
				pm_wdata = '0;
			end
			S_A: begin
				pm_we    = 1'b1;
				pm_waddr = PH_A;
				pm_wdata = pm_rdata_q + step0_q;
			end
			S_B: begin
				pm_we    = 1'b1;
				pm_waddr = PH_B;
				pm_wdata = pm_rdata_q + step1_q;
			end
			S_E: begin
				pm_we    = (region_q != dtgr_pkg::REG_CENTER);
				pm_waddr = PH_ENV;
				pm_wdata = (region_q == dtgr_pkg::REG_FALL) ? env_dec : env_inc;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (state_q)
			S_A:     pm_raddr = PH_B;
			S_B:     pm_raddr = PH_ENV;
			default: pm_raddr = PH_A;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pm_we)
			phase_mem[pm_waddr] <= pm_wdata;
		pm_rdata_q <= phase_mem[pm_raddr];
	end

	// shared amplitude multiplier
	assign s_val   = sneg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
	assign amp_sel = (state_q == S_B) ? amp0_q : amp1_q;
	assign mul_amp = 32'($signed({1'b0, amp_sel})) * 32'(s_val);
	assign mix_neg = -mix_q;
	assign scaled  = 61'(mag_q) * 61'(esq_q);

	assign out_load   = (state_q == S_OUT) && (!m_tvalid_q || m_tready);
	// magnitude stays below 2^15 in every region, so no clamp is needed
	assign sample_out = neg_q ? -{1'b0, q_q} : {1'b0, q_q};

	always_ff @(posedge clk) begin
		if (state_q == S_A)
			last_s <= last_n;
		if (state_q == S_B)
			prod0_s1 <= mul_amp;
		if (state_q == S_E)
			mix_q <= prod0_s1 + mul_amp;
		if (state_q == S_ESQ) begin
			esq_q <= 30'(rom_q) * 30'(rom_q);
			neg_q <= mix_q[31];
			mag_q <= mix_q[31] ? mix_neg[30:0] : mix_q[30:0];
		end
		if (state_q == S_SCALE)
			q_q <= (region_q == dtgr_pkg::REG_CENTER) ? mag_q[30:16] : scaled[60:46];
		if (out_load) begin
			m_tdata <= sample_out;
			m_tuser <= region_q;
			m_tlast <= last_s;
		end
	end

	// sequencer, configuration and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step0_q    <= '0;
			step1_q    <= '0;
			amp0_q     <= '0;
			amp1_q     <= '0;
			ramp_q     <= '0;
			estep_q    <= '0;
			center_q   <= '0;
			active_q   <= 1'b0;
			region_q   <= dtgr_pkg::REG_RISE;
			counter_q  <= '0;
			clr_q      <= PH_A;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					dtgr_pkg::CFG_PHASE_STEP_0:   step0_q  <= cfg_wdata[PB-1:0];
					dtgr_pkg::CFG_PHASE_STEP_1:   step1_q  <= cfg_wdata[PB-1:0];
					dtgr_pkg::CFG_AMPLITUDE_0:    amp0_q   <= cfg_wdata[dtgr_pkg::AMP_BITS-1:0];
					dtgr_pkg::CFG_AMPLITUDE_1:    amp1_q   <= cfg_wdata[dtgr_pkg::AMP_BITS-1:0];
					dtgr_pkg::CFG_RAMP_SAMPLES:   ramp_q   <= cfg_wdata[dtgr_pkg::RAMP_BITS-1:0];
					dtgr_pkg::CFG_RAMP_STEP:      estep_q  <= cfg_wdata[PB-1:0];
					dtgr_pkg::CFG_CENTER_SAMPLES: center_q <= cfg_wdata[CB-1:0];
					default: ;
				endcase
			end

			// a new sample loaded in the same cycle keeps valid high
			if (m_tvalid_q && m_tready && !out_load)
				m_tvalid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (!action) begin
							// start: rearm and clear the phase ram
							active_q  <= 1'b1;
							region_q  <= dtgr_pkg::REG_RISE;
							counter_q <= '0;
							clr_q     <= PH_A;
							state_q   <= S_CLR;
						end else if (active_q) begin
							if (tone_end) begin
								active_q <= 1'b0;
							end else begin
								region_q  <= reg_n;
								counter_q <= cnt_n;
								state_q   <= S_A;
							end
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 2'd1;
					if (clr_q == PH_ENV)
						state_q <= S_IDLE;
				end
				S_A: begin
					counter_q <= cnt_inc;
					if (last_n)
						active_q <= 1'b0;
					state_q <= S_B;
				end
				S_B:     state_q <= S_E;
				S_E:     state_q <= S_ESQ;
				S_ESQ:   state_q <= S_SCALE;
				S_SCALE: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

	// the phase ram is only written while an item is being worked on
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pm_we |-> state_q != S_IDLE)
		else $error("phase ram written while idle");

	// once a tick leaves S_A, the tone is active exactly when its sample is not the final one
	a_last_clears_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A |=> active_q == !last_s)
		else $error("tone activity disagrees with final-sample flag");

	// while clearing after a start the tone sits at the head of its rise
	a_clear_rearmed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> (region_q == dtgr_pkg::REG_RISE && counter_q == '0 && active_q))
		else $error("start did not rearm the tone");

endmodule

[tb/sv/tb_dual_tone_generator_ramped_unit.sv]
// tb_dual_tone_generator_ramped_unit: self-checking testbench for the ramped dual-tone generator
// depends on dtgr_pkg and dual_tone_generator_ramped_unit; drives start/tick transactions,
// predicts every sample in-line and checks the result stream under random idling
`timescale 1ns / 1ps

module tb_dual_tone_generator_ramped_unit;

	// input action codes carried on s_tuser[0]
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	localparam int SETTLE_CYCLES  = 16;    // a tick is done well within this after its sample
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off for the pressure test
	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction at all

	// one expected result transaction
	typedef struct packed {
		logic [15:0]       sample;
		dtgr_pkg::region_t region;
		logic              last;
	} tone_sample_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           cfg_we   = 1'b0;
	logic [dtgr_pkg::CFG_ABITS-1:0] cfg_addr = '0;
	logic [dtgr_pkg::CFG_DBITS-1:0] cfg_wdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata  = '0;   // [0] halt, [7:1] zero
	logic [0:0]                     s_tuser  = '0;   // [0] action
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [15:0]                    m_tdata;         // [15:0] sample
	logic [1:0]                     m_tuser;         // [1:0] region
	logic                           m_tlast;

	// idling controls, changed per test phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_request   = 1'b0;
	int hold_left      = 0;

	int error_count    = 0;
	int quiet_cycles   = 0;

	// expected samples, oldest first
	tone_sample_t expected_samples [$];

	// shadow copy of the configuration registers
	logic [31:0] shadow_step_0, shadow_step_1, shadow_ramp_step;
	logic [14:0] shadow_amp_0, shadow_amp_1;
	logic [10:0] shadow_ramp_len;
	logic [23:0] shadow_center_len;

	// predicted generator state
	logic [31:0]       osc_phase_a, osc_phase_b, env_phase;
	logic [23:0]       seg_count;
	dtgr_pkg::region_t tone_region;
	bit                tone_live;

	// quarter-wave sine in q15, built independently from a q30 taylor series
	int quarter_sine [0:dtgr_pkg::SINE_DEPTH];

	always #6 clk = ~clk;

	dual_tone_generator_ramped_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	function automatic void fill_quarter_sine();
		longint unsigned arg;
		longint unsigned pw;
		longint          acc;
		longint          q15;
		for (int i = 0; i <= dtgr_pkg::SINE_DEPTH; i++) begin
			arg = (longint'(1686629713) * longint'(i)) / dtgr_pkg::SINE_DEPTH;
			pw  = arg;
			acc = longint'(arg);
			// alternating odd powers, each term built from the previous one
			for (int k = 1; k <= 6; k++) begin
				pw = (pw * arg) >> 30;
				pw = (pw * arg) >> 30;
				pw = pw / longint'((2 * k) * (2 * k + 1));
				acc = (k % 2 == 1) ? acc - longint'(pw) : acc + longint'(pw);
			end
			if (acc < 0)
				acc = 0;
			q15 = (acc * 32767 + (longint'(1) << 29)) >>> 30;
			quarter_sine[i] = (q15 > 32767) ? 32767 : int'(q15);
		end
	endfunction

	// quadrant from the top two phase bits, table index from the next ten
	function automatic int sine_at(input logic [31:0] phase);
		int j;
		int v;
		j = int'(phase[29:20]);
		v = phase[30] ? quarter_sine[dtgr_pkg::SINE_DEPTH - j] : quarter_sine[j];
		return phase[31] ? -v : v;
	endfunction

	function automatic void apply_reg(input dtgr_pkg::cfg_index_t idx,
	                                  input logic [31:0] value);
		case (idx)
			dtgr_pkg::CFG_PHASE_STEP_0:   shadow_step_0     = value;
			dtgr_pkg::CFG_PHASE_STEP_1:   shadow_step_1     = value;
			dtgr_pkg::CFG_AMPLITUDE_0:    shadow_amp_0      = value[14:0];
			dtgr_pkg::CFG_AMPLITUDE_1:    shadow_amp_1      = value[14:0];
			dtgr_pkg::CFG_RAMP_SAMPLES:   shadow_ramp_len   = value[10:0];
			dtgr_pkg::CFG_RAMP_STEP:      shadow_ramp_step  = value;
			dtgr_pkg::CFG_CENTER_SAMPLES: shadow_center_len = value[23:0];
			default: ;
		endcase
	endfunction

	// advance the predicted generator by one accepted item, queue the sample it makes
	function automatic void predict_tone_step(input logic act, input logic hlt);
		int unsigned     ramp_eff;
		longint          mix;
		longint unsigned mag;
		longint unsigned q;
		longint          env;
		longint          val;
		bit              neg;
		bit              is_last;
		tone_sample_t    rec;
		ramp_eff = (shadow_ramp_len > dtgr_pkg::RAMP_MAX) ? dtgr_pkg::RAMP_MAX : shadow_ramp_len;
		if (act == ACT_START) begin
			osc_phase_a = '0;
			osc_phase_b = '0;
			env_phase   = '0;
			seg_count   = '0;
			tone_region = dtgr_pkg::REG_RISE;
			tone_live   = 1'b1;
			return;
		end
		if (!tone_live)
			return;
		// empty regions fall through within the same tick
		if (tone_region == dtgr_pkg::REG_RISE && seg_count >= ramp_eff) begin
			tone_region = dtgr_pkg::REG_CENTER;
			seg_count   = '0;
		end
		if (tone_region == dtgr_pkg::REG_CENTER
		    && (seg_count >= shadow_center_len || hlt)) begin
			tone_region = dtgr_pkg::REG_FALL;
			seg_count   = '0;
		end
		if (tone_region == dtgr_pkg::REG_FALL && seg_count >= ramp_eff) begin
			tone_live = 1'b0;
			return;
		end
		mix = longint'(shadow_amp_0) * sine_at(osc_phase_a)
		    + longint'(shadow_amp_1) * sine_at(osc_phase_b);
		osc_phase_a = osc_phase_a + shadow_step_0;
		osc_phase_b = osc_phase_b + shadow_step_1;
		neg = mix < 0;
		mag = neg ? longint'(-mix) : longint'(mix);
		if (tone_region == dtgr_pkg::REG_CENTER) begin
			q = mag >> 16;
		end else begin
			// the fall steps back first, the rise reads first
			if (tone_region == dtgr_pkg::REG_FALL)
				env_phase = env_phase - shadow_ramp_step;
			env = sine_at(env_phase);
			q = (mag * longint'(env * env)) >> 46;
			if (tone_region == dtgr_pkg::REG_RISE)
				env_phase = env_phase + shadow_ramp_step;
		end
		val = neg ? -longint'(q) : longint'(q);
		if (val > 32767)
			val = 32767;
		if (val < -32768)
			val = -32768;
		seg_count = seg_count + 24'd1;
		is_last = 1'b0;
		if (tone_region == dtgr_pkg::REG_FALL)
			is_last = seg_count >= ramp_eff;
		else if (tone_region == dtgr_pkg::REG_CENTER)
			is_last = (ramp_eff == 0) && (seg_count >= shadow_center_len);
		if (is_last)
			tone_live = 1'b0;
		rec.sample = val[15:0];
		rec.region = tone_region;
		rec.last   = is_last;
		expected_samples.push_back(rec);
	endfunction

	// input transaction monitor feeds the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			predict_tone_step(s_tuser[0], s_tdata[0]);
	end

	// result transaction checker, one field at a time against the oldest expectation
	always @(posedge clk) begin
		tone_sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				$error("unexpected result transaction: sample %0d region %0d last %0d",
				       $signed(m_tdata), m_tuser, m_tlast);
				error_count++;
			end else begin
				want = expected_samples.pop_front();
				if (m_tdata !== want.sample) begin
					$error("sample mismatch: expected %0d, actual %0d",
					       $signed(want.sample), $signed(m_tdata));
					error_count++;
				end
				if (m_tuser !== want.region) begin
					$error("region mismatch: expected %0d, actual %0d", want.region, m_tuser);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// receiver: random stalls, or a long hold-off counted here when a test asks for one
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no transaction of any kind
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one item, holding it until the block takes it; valid stays up for a follow-on item
	task automatic send_item(input logic act, input logic hlt);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, hlt};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// wait until every expected sample is out and the last item has left the pipeline
	task automatic settle_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all seven registers back to back, block must be idle
	task automatic program_tone(input logic [31:0] step_0, input logic [31:0] step_1,
	                            input logic [14:0] amp_0, input logic [14:0] amp_1,
	                            input logic [10:0] ramp_len, input logic [31:0] ramp_step,
	                            input logic [23:0] center_len);
		logic [31:0]          vals [7];
		dtgr_pkg::cfg_index_t idx;
		vals[dtgr_pkg::CFG_PHASE_STEP_0]   = step_0;
		vals[dtgr_pkg::CFG_PHASE_STEP_1]   = step_1;
		vals[dtgr_pkg::CFG_AMPLITUDE_0]    = 32'(amp_0);
		vals[dtgr_pkg::CFG_AMPLITUDE_1]    = 32'(amp_1);
		vals[dtgr_pkg::CFG_RAMP_SAMPLES]   = 32'(ramp_len);
		vals[dtgr_pkg::CFG_RAMP_STEP]      = ramp_step;
		vals[dtgr_pkg::CFG_CENTER_SAMPLES] = 32'(center_len);
		idx = idx.first();
		repeat (idx.num()) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= idx;
			cfg_wdata <= vals[idx];
			@(posedge clk);
			apply_reg(idx, vals[idx]);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
	endtask

	// registers all zero after reset: an idle tick and an empty tone give nothing
	task automatic test_idle_after_reset();
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_START, 1'b0);
		send_item(ACT_TICK, 1'b0);
		settle_block();
	endtask

	// walk every region, halts in and out of the centre, empty tones and rearming
	task automatic test_region_walk();
		// full-scale amplitudes, all-ones first phase step, two-sample ramps
		program_tone(32'hFFFF_FFFF, 32'h4000_0000, 15'h7FFF, 15'h7FFF,
		             11'd2, 32'h2000_0000, 24'd3);
		send_item(ACT_TICK, 1'b0);    // idle tick, no sample
		send_item(ACT_START, 1'b0);
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_TICK, 1'b1);    // halt during the rise is ignored
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_TICK, 1'b1);    // halt cuts the centre short
		send_item(ACT_TICK, 1'b0);    // final fall sample
		send_item(ACT_TICK, 1'b0);    // tone over, idle again
		settle_block();

		// no ramp: the centre itself carries the last flag
		program_tone(32'h0, 32'h8000_0000, 15'd0, 15'd1, 11'd0, 32'h0, 24'd2);
		send_item(ACT_START, 1'b0);
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_TICK, 1'b0);
		settle_block();

		// tone with no samples at all
		program_tone(32'h1234_5678, 32'h0, 15'h7FFF, 15'd0, 11'd0, 32'hFFFF_FFFF, 24'd0);
		send_item(ACT_START, 1'b1);
		send_item(ACT_TICK, 1'b0);
		settle_block();

		// longest centre, ended by a halt with no fall to play
		program_tone(32'h0800_0000, 32'hF000_0000, 15'h7FFF, 15'h7FFF,
		             11'd0, 32'h0, 24'hFF_FFFF);
		send_item(ACT_START, 1'b0);
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_TICK, 1'b1);
		send_item(ACT_TICK, 1'b0);
		settle_block();

		// largest envelope step, restart while a tone is running
		program_tone(32'h0100_0000, 32'h0300_0000, 15'h5555, 15'h2AAA,
		             11'd3, 32'hFFFF_FFFF, 24'd1);
		send_item(ACT_START, 1'b0);
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_START, 1'b0);
		send_item(ACT_TICK, 1'b0);
		settle_block();
	endtask

	// ramp count above the maximum saturates; the fall is then shortened mid-tone
	task automatic test_ramp_saturation();
		logic [31:0] step_0;
		logic [31:0] step_1;
		step_0 = $urandom;
		step_1 = $urandom;
		program_tone(step_0, step_1, 15'h7FFF, 15'h7FFF, 11'h7FF, 32'h0010_0000, 24'd1);
		send_item(ACT_START, 1'b0);
		// full rise, then one centre sample
		repeat (dtgr_pkg::RAMP_MAX + 1) send_item(ACT_TICK, 1'b0);
		settle_block();
		program_tone(step_0, step_1, 15'h7FFF, 15'h7FFF, 11'd1, 32'h0010_0000, 24'd1);
		send_item(ACT_TICK, 1'b0);    // single fall sample, last
		send_item(ACT_TICK, 1'b0);
		settle_block();
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_backpressure();
		program_tone($urandom, $urandom, 15'h7FFF, 15'h1000, 11'd4, 32'h1000_0000, 24'd60);
		send_item(ACT_START, 1'b0);
		hold_request = 1'b1;
		repeat (40) send_item(ACT_TICK, $urandom_range(99) < 3);
		settle_block();
	endtask

	function automatic logic [14:0] pick_amplitude();
		case ($urandom_range(3))
			0:       return 15'd0;
			1:       return 15'h7FFF;
			default: return 15'($urandom);
		endcase
	endfunction

	// random tones with short regions, occasional cut-short or restarted tones
	task automatic test_random_tones(input int item_goal);
		int          counted;
		int          ramp_n;
		int          center_n;
		int          tone_len;
		int          n_ticks;
		logic [31:0] env_step;
		counted = 0;
		while (counted < item_goal) begin
			settle_block();
			ramp_n   = ($urandom_range(99) < 75) ? $urandom_range(6) : $urandom_range(40, 7);
			center_n = ($urandom_range(99) < 80) ? $urandom_range(10) : $urandom_range(60, 11);
			if (ramp_n > 0 && $urandom_range(1))
				env_step = 32'h4000_0000 / ramp_n;
			else
				env_step = $urandom;
			program_tone($urandom, $urandom, pick_amplitude(), pick_amplitude(),
			             11'(ramp_n), env_step, 24'(center_n));
			send_item(ACT_START, 1'($urandom_range(1)));
			counted++;
			tone_len = 2 * ramp_n + center_n + 1;
			// mostly complete tones with a little idle tail, some broken off early
			if ($urandom_range(99) < 85)
				n_ticks = tone_len + $urandom_range(2);
			else
				n_ticks = $urandom_range(tone_len);
			for (int i = 0; i < n_ticks; i++) begin
				if ($urandom_range(99) < 3)
					send_item(ACT_START, 1'($urandom_range(1)));
				else
					send_item(ACT_TICK, $urandom_range(99) < 8);
				if (i < tone_len)
					counted++;
			end
		end
		settle_block();
	endtask

	initial begin
		fill_quarter_sine();
		apply_reg(dtgr_pkg::CFG_PHASE_STEP_0, '0);
		apply_reg(dtgr_pkg::CFG_PHASE_STEP_1, '0);
		apply_reg(dtgr_pkg::CFG_AMPLITUDE_0, '0);
		apply_reg(dtgr_pkg::CFG_AMPLITUDE_1, '0);
		apply_reg(dtgr_pkg::CFG_RAMP_SAMPLES, '0);
		apply_reg(dtgr_pkg::CFG_RAMP_STEP, '0);
		apply_reg(dtgr_pkg::CFG_CENTER_SAMPLES, '0);
		osc_phase_a = '0;
		osc_phase_b = '0;
		env_phase   = '0;
		seg_count   = '0;
		tone_region = dtgr_pkg::REG_RISE;
		tone_live   = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		test_region_walk();
		test_ramp_saturation();
		test_backpressure();

		// idling phases: none, sender idle, receiver stalling, both
		send_idle_pct = 0;  recv_stall_pct = 0;
		test_random_tones(130);
		send_idle_pct = 77; recv_stall_pct = 0;
		test_random_tones(130);
		send_idle_pct = 0;  recv_stall_pct = 77;
		test_random_tones(130);
		send_idle_pct = 16; recv_stall_pct = 16;
		test_random_tones(130);

		// catch any stray result after the last expectation
		recv_stall_pct = 0;
		settle_block();
		if (error_count == 0 && expected_samples.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
